// File: rtl/contact_enter_stay_exit_tracker_macros.svh
// Assertion macros for the contact tracker checker
`ifndef CONTACT_ENTER_STAY_EXIT_TRACKER_MACROS_SVH
`define CONTACT_ENTER_STAY_EXIT_TRACKER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define CEST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CEST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cest_pkg.sv
// Types and result codes shared by the contact tracker files
package cest_pkg;

    localparam int KEY_W = 64;
    localparam int RES_W = 3;

    localparam logic [RES_W-1:0] RES_ENTER   = 3'd0;
    localparam logic [RES_W-1:0] RES_STAY    = 3'd1;
    localparam logic [RES_W-1:0] RES_EXIT    = 3'd2;
    localparam logic [RES_W-1:0] RES_DROPPED = 3'd3;
    localparam logic [RES_W-1:0] RES_DONE    = 3'd4;

    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] pair_key;
    } t_in_item;

    typedef struct packed {
        logic [RES_W-1:0] event_res;
        logic [KEY_W-1:0] event_key;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic             unseen;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic shift;
        logic wr;
        logic seen;
    } t_cell_ctl;

endpackage

// File: rtl/contact_enter_stay_exit_tracker.sv
// Contact tracker top level: slot chain plus lookup/sweep sequencer
//
//   channel   dir  handshake            payload
//   item      in   start && !busy       i_item  (kind, pair_key)
//   result    out  o_valid, one cycle   o_res   (event_res, event_key, last)
//
// Pair item: accept, then match against all slots; a new pair
// adds a trailing stay result after its enter result.
// End of frame: the slot chain rotates once past slot 0, which is
// checked for an exit each cycle, then frame done follows.
// Synchronous active-low reset clears all slot flags; keys are not cleared.
// The receiver cannot stall: each result shows on o_res for one cycle.
module contact_enter_stay_exit_tracker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cest_pkg::t_in_item    i_item,
    output logic                  o_valid,
    output cest_pkg::t_out_item   o_res
);

    localparam int CW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_STAY2,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [cest_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]              r_cnt;
    logic                       r_valid;
    cest_pkg::t_out_item        r_res;

    cest_pkg::t_slot     slot_q   [TABLE_DEPTH];
    cest_pkg::t_slot     wrap_slot;
    cest_pkg::t_cell_ctl ctl      [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] free_vec;
    logic [TABLE_DEPTH-1:0] free_first;
    logic                   hit;
    logic                   any_free;
    logic                   accept;
    logic                   stale0;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            free_vec[i] = !slot_q[i].valid;
        end
    end

    assign free_first = free_vec & (~free_vec + TABLE_DEPTH'(1));
    assign any_free   = |free_vec;
    assign hit        = |match_vec;

    // slot 0 wraps to the tail; a stale pair is dropped, survivors get marked unseen
    assign stale0           = slot_q[0].valid && slot_q[0].unseen;
    assign wrap_slot.valid  = slot_q[0].valid && !slot_q[0].unseen;
    assign wrap_slot.unseen = slot_q[0].valid && !slot_q[0].unseen;
    assign wrap_slot.key    = slot_q[0].key;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            assign ctl[g].shift = (r_state == S_SWEEP);
            assign ctl[g].wr    = (r_state == S_LOOK) && !hit && free_first[g];
            assign ctl[g].seen  = (r_state == S_LOOK) && match_vec[g];

            if (g == TABLE_DEPTH - 1) begin : g_tail
                cest_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_ctl      (ctl[g]),
                    .i_shift_in (wrap_slot),
                    .i_key      (r_key),
                    .o_slot     (slot_q[g]),
                    .o_match    (match_vec[g])
                );
            end else begin : g_body
                cest_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_ctl      (ctl[g]),
                    .i_shift_in (slot_q[g+1]),
                    .i_key      (r_key),
                    .o_slot     (slot_q[g]),
                    .o_match    (match_vec[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cnt <= '0;
                        if (i_item.kind == cest_pkg::KIND_EOF) begin
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_valid <= 1'b1;
                    priority if (hit) begin
                        r_res.event_res <= cest_pkg::RES_STAY;
                        r_res.last      <= 1'b1;
                        r_state         <= S_IDLE;
                    end else if (any_free) begin
                        r_res.event_res <= cest_pkg::RES_ENTER;
                        r_res.last      <= 1'b0;
                        r_state         <= S_STAY2;
                    end else begin
                        r_res.event_res <= cest_pkg::RES_DROPPED;
                        r_res.last      <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                    r_res.event_key <= r_key;
                end
                S_STAY2: begin
                    r_valid         <= 1'b1;
                    r_res.event_res <= cest_pkg::RES_STAY;
                    r_res.event_key <= r_key;
                    r_res.last      <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_SWEEP: begin
                    r_valid         <= stale0;
                    r_res.event_res <= cest_pkg::RES_EXIT;
                    r_res.event_key <= slot_q[0].key;
                    r_res.last      <= 1'b0;
                    r_cnt           <= r_cnt + CW'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid         <= 1'b1;
                    r_res.event_res <= cest_pkg::RES_DONE;
                    r_res.event_key <= '0;
                    r_res.last      <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_item.pair_key;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/cest_cell.sv
// One table slot: holds a pair key with valid/unseen flags, shifts to its neighbor
module cest_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cest_pkg::t_cell_ctl           i_ctl,
    input  cest_pkg::t_slot               i_shift_in,
    input  logic [cest_pkg::KEY_W-1:0]    i_key,
    output cest_pkg::t_slot               o_slot,
    output logic                          o_match
);

    logic                       r_valid;
    logic                       r_unseen;
    logic [cest_pkg::KEY_W-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_unseen <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid  <= i_shift_in.valid;
            r_unseen <= i_shift_in.unseen;
        end else if (i_ctl.wr) begin
            r_valid  <= 1'b1;
            r_unseen <= 1'b0;
        end else if (i_ctl.seen) begin
            r_unseen <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_shift_in.key;
        end else if (i_ctl.wr) begin
            r_key <= i_key;
        end
    end

    assign o_slot.valid  = r_valid;
    assign o_slot.unseen = r_unseen;
    assign o_slot.key    = r_key;
    assign o_match       = r_valid && (r_key == i_key);

endmodule

// File: rtl/cest_checker.sv
// Port-level checker for the contact tracker, bound to the top level
`include "contact_enter_stay_exit_tracker_macros.svh"

module cest_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input cest_pkg::t_out_item o_res
);

    `CEST_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `CEST_ASSERT_IMP(a_last_idle, o_valid && o_res.last, !busy, "busy after final result")
    `CEST_ASSERT_IMP(a_mid_busy, o_valid && !o_res.last, busy, "idle while results pending")
    `CEST_ASSERT_IMP(a_done_last, o_valid && (o_res.event_res == cest_pkg::RES_DONE), o_res.last && (o_res.event_key == '0), "frame done not final or key nonzero")
    `CEST_ASSERT_NXT(a_enter_stay, o_valid && (o_res.event_res == cest_pkg::RES_ENTER), o_valid && (o_res.event_res == cest_pkg::RES_STAY) && (o_res.event_key == $past(o_res.event_key)), "enter not followed by stay")

endmodule

bind contact_enter_stay_exit_tracker cest_checker u_cest_checker (.*);

// File: tb/tb_contact_enter_stay_exit_tracker.sv
// Testbench for the contact tracker: random frames of pair items checked against a predicted table
`timescale 1ns / 1ps

module tb_contact_enter_stay_exit_tracker;
    import cest_pkg::*;

    localparam int TBL_DEPTH   = 32;
    localparam int ITEM_TARGET = 480;
    localparam int CALM_AFTER  = 420;  // no idling past this many items
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = TBL_DEPTH + 20;

    // Predicted pair table plus the queue of events it says must come out
    class contact_events_board;
        logic [KEY_W-1:0] slot_key [TBL_DEPTH];
        bit               slot_used [TBL_DEPTH];
        bit               slot_stale [TBL_DEPTH];
        t_out_item        expected_events [$];
        int               fails;

        function void push_event(logic [RES_W-1:0] res, logic [KEY_W-1:0] key, logic lst);
            t_out_item ev;
            ev.event_res = res;
            ev.event_key = key;
            ev.last      = lst;
            expected_events.insert(expected_events.size(), ev);
        endfunction

        function void apply_item(t_in_item it);
            int hit;
            int free_slot;
            hit       = -1;
            free_slot = -1;
            if (it.kind == KIND_PAIR) begin
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (slot_used[i]) begin
                        if (hit < 0 && slot_key[i] == it.pair_key)
                            hit = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    slot_stale[hit] = 0;
                    push_event(RES_STAY, it.pair_key, 1'b1);
                end else if (free_slot >= 0) begin
                    slot_key[free_slot]   = it.pair_key;
                    slot_used[free_slot]  = 1;
                    slot_stale[free_slot] = 0;
                    push_event(RES_ENTER, it.pair_key, 1'b0);
                    push_event(RES_STAY, it.pair_key, 1'b1);
                end else begin
                    push_event(RES_DROPPED, it.pair_key, 1'b1);
                end
            end else begin
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (slot_used[i] && slot_stale[i]) begin
                        push_event(RES_EXIT, slot_key[i], 1'b0);
                        slot_used[i]  = 0;
                        slot_stale[i] = 0;
                    end
                end
                push_event(RES_DONE, '0, 1'b1);
                for (int i = 0; i < TBL_DEPTH; i++)
                    slot_stale[i] = slot_used[i];
            end
        endfunction

        function void check_event(t_out_item got);
            t_out_item want;
            if (expected_events.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: res=%0d key=%h last=%0b",
                             got.event_res, got.event_key, got.last);
                return;
            end
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res || got.event_key !== want.event_key ||
                got.last !== want.last) begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: expected res=%0d key=%h last=%0b, got res=%0d key=%h last=%0b",
                             want.event_res, want.event_key, want.last,
                             got.event_res, got.event_key, got.last);
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_res;

    contact_events_board board;
    logic [KEY_W-1:0]    key_pool [$];
    int                  items_sent;
    int                  stall_cycles;

    contact_enter_stay_exit_tracker #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Results and handshakes are sampled mid-cycle, where every signal is settled
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_event(o_res);
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Called just after a rising edge; returns at the edge that takes the item
    task automatic send_item(logic kind, logic [KEY_W-1:0] key);
        t_in_item it;
        it.kind     = kind;
        it.pair_key = key;
        start  <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (busy);
        board.apply_item(it);
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic idle_for(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0)
            @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int fresh_pct);
        logic [KEY_W-1:0] k;
        if ($urandom_range(99) < fresh_pct || key_pool.size() == 0) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: k = '0;
                    1: k = '1;
                    2: k = 64'd1 << $urandom_range(63);
                    default: k = ~(64'd1 << $urandom_range(63));
                endcase
            end else begin
                k = {$urandom, $urandom};
            end
            key_pool.insert(key_pool.size(), k);
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end else begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        end
        return k;
    endfunction

    task automatic run_frame();
        int  n_pairs;
        int  fresh_pct;
        int  r;
        bit  bursty;
        r = $urandom_range(99);
        if (r < 10) begin
            n_pairs   = 0;
            fresh_pct = 0;
        end else if (r < 24) begin
            // many new keys, which can fill the table and overflow it
            n_pairs   = $urandom_range(30, 40);
            fresh_pct = 90;
        end else begin
            n_pairs   = $urandom_range(1, 10);
            fresh_pct = 35;
        end
        bursty = ($urandom_range(2) != 0);
        for (int p = 0; p <= n_pairs; p++) begin
            if (bursty && items_sent < CALM_AFTER && $urandom_range(3) == 0)
                idle_for($urandom_range(1, 12));
            if (p < n_pairs)
                send_item(KIND_PAIR, pick_key(fresh_pct));
            else
                send_item(KIND_EOF, {$urandom, $urandom});
        end
    endtask

    initial begin
        board        = new;
        items_sent   = 0;
        stall_cycles = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // edge keys, repeats within a frame, stale sweeps, empty frames
        send_item(KIND_PAIR, '0);
        send_item(KIND_PAIR, '1);
        send_item(KIND_PAIR, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(KIND_PAIR, 64'h5555_5555_5555_5555);
        send_item(KIND_PAIR, '0);
        send_item(KIND_EOF, '1);
        send_item(KIND_PAIR, '1);
        send_item(KIND_EOF, '0);
        send_item(KIND_EOF, 64'h5555_5555_5555_5555);
        send_item(KIND_EOF, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(KIND_PAIR, 64'h8000_0000_0000_0001);
        send_item(KIND_PAIR, 64'h0000_0000_0000_0001);
        send_item(KIND_PAIR, 64'h8000_0000_0000_0001);
        send_item(KIND_EOF, '0);
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            run_frame();
            if (items_sent < CALM_AFTER && $urandom_range(9) == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending() > 0) begin
            board.fails++;
            $display("%0d expected results never came", board.pending());
        end
        if (board.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
